// ===== hdl/ptts_pkg.sv =====
`timescale 1ns / 1ps

package ptts_pkg;

  // Field widths of the input and result channels.
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned MS_W         = 32;
  localparam int unsigned SLOT_INDEX_W = 6;
  localparam int unsigned STATUS_W     = 3;

  // Widths of the per-slot fields: countdown and period in ticks, then the pending-run count.
  localparam int unsigned TICKS_W   = 29;
  localparam int unsigned PENDING_W = 8;

  // Default table size.
  localparam int unsigned TASK_SLOTS_DEFAULT = 16;

  // Milliseconds to ticks: x / 10 is (x * RECIP) >> SHIFT for every 32-bit x.
  localparam logic [MS_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned     DIV10_SHIFT = 35;

  // Saturation value of the pending-run count.
  localparam logic [PENDING_W-1:0] PENDING_MAX = '1;

  // Action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_DELETE   = 2'd3
  } action_t;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd4;

  // One entry of the slot memory.
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [TICKS_W-1:0]   countdown;
    logic [TICKS_W-1:0]   period;
    logic [PENDING_W-1:0] pending;
  } slot_entry_t;

endpackage

// ===== hdl/ptts_div10.sv =====
`timescale 1ns / 1ps

// Divides a 32-bit millisecond value by ten through a registered multiply by
// the reciprocal. The quotient is valid in the cycle after the operand.
module ptts_div10 (
  input  logic                          clk,
  input  logic [ptts_pkg::MS_W-1:0]     x,
  output logic [ptts_pkg::TICKS_W-1:0]  q
);
  import ptts_pkg::*;

  logic [2*MS_W-1:0] prod;

  // Product register.
  always_ff @(posedge clk) begin
    prod <= x * DIV10_RECIP;
  end

  // The quotient is the top part of the product.
  assign q = prod[DIV10_SHIFT +: TICKS_W];

endmodule

// ===== hdl/periodic_task_table_scheduler_core.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Fields
// input    in_valid / in_ready  action, task_handle, delay_ms, period_ms, slot_index
// output   out_valid/out_ready  status, result_slot, run_handle, last_result
//
// Add searches the table one slot at a time for a free slot, converts the delay
// and the period in the divide-by-ten multiplier and then writes the entry.
// Tick and dispatch walk every slot: each valid slot costs a memory read and a
// write-back step, a free slot only its check. Delete reports on one slot index
// and clears it if it lies in the table. Reset clears the valid bits at once; no
// clearing pass. A full output register stalls a dispatch walk when a held result
// must go out; the next item is taken while the last result still waits.
module periodic_task_table_scheduler_core #(
  parameter int unsigned TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ptts_pkg::ACTION_W-1:0]      action,
  input  logic [ptts_pkg::HANDLE_W-1:0]      task_handle,
  input  logic [ptts_pkg::MS_W-1:0]          delay_ms,
  input  logic [ptts_pkg::MS_W-1:0]          period_ms,
  input  logic [ptts_pkg::SLOT_INDEX_W-1:0]  slot_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptts_pkg::STATUS_W-1:0]      status,
  output logic [ptts_pkg::SLOT_INDEX_W-1:0]  result_slot,
  output logic [ptts_pkg::HANDLE_W-1:0]      run_handle,
  output logic                               last_result
);
  import ptts_pkg::*;

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
  localparam logic [SLOT_INDEX_W:0] SLOT_LIMIT = (SLOT_INDEX_W + 1)'(TASK_SLOTS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FIND = 9'b000000010,
    S_MULD = 9'b000000100,
    S_MULP = 9'b000001000,
    S_WADD = 9'b000010000,
    S_READ = 9'b000100000,
    S_MOD  = 9'b001000000,
    S_DONE = 9'b010000000,
    S_DEL  = 9'b100000000
  } state_t;

  state_t state;

  // Captured input item.
  action_t                   action_q;
  logic [HANDLE_W-1:0]       handle_q;
  logic [MS_W-1:0]           delay_q;
  logic [MS_W-1:0]           period_q;
  logic [SLOT_INDEX_W-1:0]   slot_index_q;

  // Walk position and valid bits.
  logic [IDX_W-1:0]          idx;
  logic [TASK_SLOTS-1:0]     slot_valid;

  // Dispatch result held back until it is known whether it is the last one.
  logic                      hold_valid;
  logic [IDX_W-1:0]          hold_slot;
  logic [HANDLE_W-1:0]       hold_handle;

  // Divider and converted delay.
  logic [MS_W-1:0]           div_x;
  logic [TICKS_W-1:0]        div_q;
  logic [TICKS_W-1:0]        delay_ticks;

  // Slot memory.
  slot_entry_t               slot_mem [TASK_SLOTS];
  slot_entry_t               rd_data;
  slot_entry_t               mem_wdata;
  logic                      mem_we;
  logic                      mem_rd;

  logic                      out_free;
  logic                      mod_go;
  logic                      del_bad;
  logic [IDX_W-1:0]          del_idx;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign del_bad  = ({1'b0, slot_index_q} >= SLOT_LIMIT);
  assign del_idx  = slot_index_q[IDX_W-1:0];

  // A pending slot in a dispatch may have to push the held result out first.
  assign mod_go = (action_q == ACT_TICK) || (rd_data.pending == '0) ||
                  !hold_valid || out_free;

  // Shared divide-by-ten unit: delay first, then period.
  assign div_x = (state == S_MULD) ? delay_q : period_q;

  ptts_div10 u_div10 (
    .clk (clk),
    .x   (div_x),
    .q   (div_q)
  );

  // Memory access control.
  assign mem_rd = (state == S_READ) && slot_valid[idx];
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data;
    case (state)
      S_WADD: begin
        mem_we    = out_free;
        mem_wdata = '{handle: handle_q, countdown: delay_ticks,
                      period: div_q, pending: '0};
      end
      S_MOD: begin
        if (action_q == ACT_TICK) begin
          mem_we = 1'b1;
          if (rd_data.countdown == '0) begin
            if (rd_data.pending != PENDING_MAX) begin
              mem_wdata.pending = rd_data.pending + 1'b1;
            end
            if (rd_data.period != '0) begin
              mem_wdata.countdown = rd_data.period;
            end
          end else begin
            mem_wdata.countdown = rd_data.countdown - 1'b1;
          end
        end else begin
          mem_we            = mod_go && (rd_data.pending != '0);
          mem_wdata.pending = rd_data.pending - 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Slot memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data <= slot_mem[idx];
    end
  end

  // Sequencer, valid bits and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      slot_valid <= '0;
      idx        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            action_q     <= action_t'(action);
            handle_q     <= task_handle;
            delay_q      <= delay_ms;
            period_q     <= period_ms;
            slot_index_q <= slot_index;
            idx          <= '0;
            hold_valid   <= 1'b0;
            case (action_t'(action))
              ACT_ADD:      state <= S_FIND;
              ACT_TICK:     state <= S_READ;
              ACT_DISPATCH: state <= S_READ;
              ACT_DELETE:   state <= S_DEL;
              default:      state <= S_IDLE;
            endcase
          end
        end
        S_FIND: begin
          if (!slot_valid[idx]) begin
            state <= S_MULD;
          end else if (idx == LAST_IDX) begin
            if (out_free) begin
              out_valid   <= 1'b1;
              status      <= ST_FULL;
              result_slot <= '0;
              run_handle  <= '0;
              last_result <= 1'b1;
              state       <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MULD: begin
          state <= S_MULP;
        end
        S_MULP: begin
          delay_ticks <= div_q;
          state       <= S_WADD;
        end
        S_WADD: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            status          <= ST_OK;
            result_slot     <= SLOT_INDEX_W'(idx);
            run_handle      <= '0;
            last_result     <= 1'b1;
            slot_valid[idx] <= 1'b1;
            state           <= S_IDLE;
          end
        end
        S_READ: begin
          if (slot_valid[idx]) begin
            state <= S_MOD;
          end else if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MOD: begin
          if (mod_go) begin
            // A pending slot in a dispatch becomes the held result.
            if ((action_q == ACT_DISPATCH) && (rd_data.pending != '0)) begin
              if (hold_valid) begin
                out_valid   <= 1'b1;
                status      <= ST_OK;
                result_slot <= SLOT_INDEX_W'(hold_slot);
                run_handle  <= hold_handle;
                last_result <= 1'b0;
              end
              hold_valid  <= 1'b1;
              hold_slot   <= idx;
              hold_handle <= rd_data.handle;
              if (rd_data.period == '0) begin
                slot_valid[idx] <= 1'b0;
              end
            end
            if (idx == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            last_result <= 1'b1;
            if (action_q == ACT_DISPATCH && hold_valid) begin
              status      <= ST_OK;
              result_slot <= SLOT_INDEX_W'(hold_slot);
              run_handle  <= hold_handle;
            end else begin
              status      <= (action_q == ACT_DISPATCH) ? ST_NONE : ST_OK;
              result_slot <= '0;
              run_handle  <= '0;
            end
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_DEL: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_slot <= slot_index_q;
            run_handle  <= '0;
            last_result <= 1'b1;
            if (del_bad) begin
              status <= ST_BADIDX;
            end else begin
              status              <= slot_valid[del_idx] ? ST_OK : ST_EMPTY;
              slot_valid[del_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A held dispatch result only exists while a dispatch is being walked.
  a_hold_dispatch : assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (action_q == ACT_DISPATCH))
    else $error("held result outside a dispatch");

  // Only dispatch results that are not the final one carry last_result low.
  a_not_last_ok : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_result) |-> (status == ST_OK))
    else $error("non-final result with a status other than ok");

  // Add only ever claims a free slot.
  a_add_free : assert property (@(posedge clk) disable iff (rst)
    (state == S_WADD && out_free) |-> !slot_valid[idx])
    else $error("add overwrote a slot in use");

  // A bad index report always names an index beyond the table.
  a_badidx_range : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BADIDX) |-> ({1'b0, result_slot} >= SLOT_LIMIT))
    else $error("bad index reported for an index inside the table");

  // An accepted item keeps the input side closed on the next cycle.
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in progress");

endmodule

// ===== dv/periodic_task_table_scheduler_core_tb.sv =====
`timescale 1ns / 1ps

module periodic_task_table_scheduler_core_tb;
  import ptts_pkg::*;

  localparam int unsigned SLOTS       = TASK_SLOTS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 2 * SLOTS + 10;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_INDEX_W-1:0] slot;
    logic [HANDLE_W-1:0]     handle;
    logic                    last;
  } sched_result_t;

  // Mirror of the slot table and the queue of results it predicts.
  class task_table_tracker;
    bit                   used[SLOTS];
    logic [HANDLE_W-1:0]  handle[SLOTS];
    logic [TICKS_W-1:0]   countdown[SLOTS];
    logic [TICKS_W-1:0]   period[SLOTS];
    logic [PENDING_W-1:0] pending[SLOTS];
    sched_result_t        awaited_results[$];
    int unsigned          errors;
    int unsigned          requests;
    int unsigned          results_seen;
    int unsigned          status_count[5];

    function new();
      for (int s = 0; s < SLOTS; s++) free_slot(s);
      errors = 0;
      requests = 0;
      results_seen = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void free_slot(int s);
      used[s] = 1'b0;
      handle[s] = '0;
      countdown[s] = '0;
      period[s] = '0;
      pending[s] = '0;
    endfunction

    function void expect_result(logic [STATUS_W-1:0] st, logic [SLOT_INDEX_W-1:0] sl,
                                logic [HANDLE_W-1:0] hd, logic lst);
      sched_result_t r;
      r.status = st;
      r.slot = sl;
      r.handle = hd;
      r.last = lst;
      awaited_results.push_back(r);
      status_count[st]++;
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    // A used slot most of the time, so that deletes mostly hit live tasks.
    function logic [SLOT_INDEX_W-1:0] pick_used_slot();
      int live[$];
      for (int s = 0; s < SLOTS; s++)
        if (used[s]) live.push_back(s);
      if (live.size() == 0 || $urandom_range(0, 4) == 0)
        return SLOT_INDEX_W'($urandom_range(0, SLOTS - 1));
      return SLOT_INDEX_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    // Updates the table for one accepted request and queues its results.
    function void apply_request(action_t act, logic [HANDLE_W-1:0] hnd,
                                logic [MS_W-1:0] dly, logic [MS_W-1:0] per,
                                logic [SLOT_INDEX_W-1:0] idx);
      int s;
      int n;
      requests++;
      case (act)
        ACT_ADD: begin
          s = 0;
          while (s < SLOTS && used[s]) s++;
          if (s >= SLOTS) begin
            expect_result(ST_FULL, '0, '0, 1'b1);
          end else begin
            used[s] = 1'b1;
            handle[s] = hnd;
            countdown[s] = TICKS_W'(dly / 32'd10);
            period[s] = TICKS_W'(per / 32'd10);
            pending[s] = '0;
            expect_result(ST_OK, SLOT_INDEX_W'(s), '0, 1'b1);
          end
        end
        ACT_TICK: begin
          for (s = 0; s < SLOTS; s++) begin
            if (!used[s]) continue;
            if (countdown[s] == '0) begin
              if (pending[s] != PENDING_MAX) pending[s]++;
              if (period[s] != '0) countdown[s] = period[s];
            end else begin
              countdown[s]--;
            end
          end
          expect_result(ST_OK, '0, '0, 1'b1);
        end
        ACT_DISPATCH: begin
          n = 0;
          for (s = 0; s < SLOTS; s++) begin
            if (!used[s] || pending[s] == '0) continue;
            expect_result(ST_OK, SLOT_INDEX_W'(s), handle[s], 1'b0);
            n++;
            pending[s]--;
            if (period[s] == '0) free_slot(s);
          end
          // The final report of a dispatch carries the last mark.
          if (n == 0) expect_result(ST_NONE, '0, '0, 1'b1);
          else awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
        default: begin
          if (idx >= SLOTS) begin
            expect_result(ST_BADIDX, idx, '0, 1'b1);
          end else begin
            expect_result(used[idx] ? ST_OK : ST_EMPTY, idx, '0, 1'b1);
            free_slot(int'(idx));
          end
        end
      endcase
    endfunction

    function void report_field(string name, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t ns: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    endfunction

    // Compares one result transfer with the oldest awaited result.
    function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_INDEX_W-1:0] sl,
                               logic [HANDLE_W-1:0] hd, logic lst);
      sched_result_t e;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result: status %0d slot %0d handle %0d last %0d",
                 $time, st, sl, hd, lst);
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      if (st !== e.status) report_field("status", e.status, st);
      if (sl !== e.slot) report_field("result_slot", e.slot, sl);
      if (hd !== e.handle) report_field("run_handle", e.handle, hd);
      if (lst !== e.last) report_field("last_result", e.last, lst);
    endfunction
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ACTION_W-1:0]     action = '0;
  logic [HANDLE_W-1:0]     task_handle = '0;
  logic [MS_W-1:0]         delay_ms = '0;
  logic [MS_W-1:0]         period_ms = '0;
  logic [SLOT_INDEX_W-1:0] slot_index = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_INDEX_W-1:0] result_slot;
  logic [HANDLE_W-1:0]     run_handle;
  logic                    last_result;

  task_table_tracker table_mirror;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  int unsigned       hold_requests = 0;
  int unsigned       cycle_count = 0;

  periodic_task_table_scheduler_core #(
    .TASK_SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .task_handle(task_handle),
    .delay_ms(delay_ms),
    .period_ms(period_ms),
    .slot_index(slot_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .result_slot(result_slot),
    .run_handle(run_handle),
    .last_result(last_result)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results awaited.", cycle_count,
               table_mirror.outstanding());
      $display("** periodic_task_table_scheduler_core: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Every result transfer is checked against the oldest awaited result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      table_mirror.check_result(status, result_slot, run_handle, last_result);
  end

  // Offers one request, after a random gap, and returns once it is transferred.
  task automatic send_item(action_t act, logic [HANDLE_W-1:0] hnd, logic [MS_W-1:0] dly,
                           logic [MS_W-1:0] per, logic [SLOT_INDEX_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    task_handle <= hnd;
    delay_ms <= dly;
    period_ms <= per;
    slot_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    table_mirror.apply_request(act, hnd, dly, per, idx);
  endtask

  // Mostly well-formed traffic: short delays and periods so that tasks fire,
  // deletes aimed at live slots, with some huge timings and bad indexes mixed in.
  task automatic send_random_item();
    int unsigned             pick;
    action_t                 act;
    logic [HANDLE_W-1:0]     hnd;
    logic [MS_W-1:0]         dly;
    logic [MS_W-1:0]         per;
    logic [SLOT_INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    hnd = HANDLE_W'($urandom);
    dly = $urandom;
    per = $urandom;
    idx = SLOT_INDEX_W'($urandom);
    if (pick < 32) begin
      act = ACT_ADD;
      case ($urandom_range(0, 9))
        0: ;
        1: dly = '1;
        default: dly = $urandom_range(0, 60);
      endcase
      case ($urandom_range(0, 9))
        0: ;
        1: per = '1;
        2, 3, 4: per = $urandom_range(0, 9);
        default: per = $urandom_range(10, 60);
      endcase
    end else if (pick < 60) begin
      act = ACT_TICK;
    end else if (pick < 80) begin
      act = ACT_DISPATCH;
    end else begin
      act = ACT_DELETE;
      if (pick < 95) idx = table_mirror.pick_used_slot();
    end
    send_item(act, hnd, dly, per, idx);
  endtask

  // Stops offering requests until every awaited result has been transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (table_mirror.outstanding() != 0) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    table_mirror = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table cases, field extremes, a multi-result dispatch,
    // then filling the table until an add is refused.
    send_item(ACT_DISPATCH, '0, '0, '0, '0);
    send_item(ACT_DELETE, '0, '0, '0, 6'd0);
    send_item(ACT_DELETE, '1, '1, '1, 6'd63);
    send_item(ACT_DELETE, '0, '0, '0, SLOT_INDEX_W'(SLOTS));
    send_item(ACT_ADD, 16'h0000, 32'd0, 32'd0, '0);
    send_item(ACT_ADD, 16'hFFFF, 32'd9, 32'd10, '0);
    send_item(ACT_ADD, 16'h1234, '1, '1, '0);
    send_item(ACT_TICK, '0, '0, '0, '0);
    send_item(ACT_TICK, '1, '1, '1, '1);
    send_item(ACT_DISPATCH, '1, '1, '1, '1);
    send_item(ACT_DELETE, '0, '0, '0, 6'd2);
    send_item(ACT_DELETE, '0, '0, '0, SLOT_INDEX_W'(SLOTS - 1));
    send_item(ACT_DISPATCH, '0, '0, '0, '0);
    for (int i = 0; i < SLOTS; i++)
      send_item(ACT_ADD, HANDLE_W'(i * 16'h1111), MS_W'(i * 10), 32'd20, '0);
    send_item(ACT_TICK, '0, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0, '0);
    wait_drained();

    // Random traffic with a slow receiver.
    tx_idle_pct = 6;
    rx_idle_pct = 79;
    repeat (22) send_random_item();
    wait_drained();

    // Random traffic with a slow sender.
    tx_idle_pct = 79;
    rx_idle_pct = 6;
    repeat (22) send_random_item();
    wait_drained();

    // No idling. First a long receiver hold-off while periodic tasks keep
    // firing, so that the result path backs up into the request side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (4) send_item(ACT_ADD, HANDLE_W'($urandom), 32'd0, 32'd10, '0);
    hold_requests++;
    for (int i = 0; i < 10; i++)
      send_item(i % 2 ? ACT_DISPATCH : ACT_TICK, HANDLE_W'($urandom), $urandom,
                $urandom, SLOT_INDEX_W'($urandom));

    // A one-shot task left undispatched for 256 ticks must stop at the
    // pending ceiling rather than wrap to zero.
    send_item(ACT_DELETE, '0, '0, '0, 6'd0);
    send_item(ACT_ADD, 16'hA5A5, 32'd0, 32'd5, '0);
    repeat (256)
      send_item(ACT_TICK, HANDLE_W'($urandom), $urandom, $urandom, SLOT_INDEX_W'($urandom));
    send_item(ACT_DISPATCH, '0, '0, '0, '0);

    repeat (10) send_random_item();

    // Let the block settle, then report.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (table_mirror.outstanding() != 0) begin
      $display("%0d awaited results never arrived.", table_mirror.outstanding());
      table_mirror.errors += table_mirror.outstanding();
    end
    $display("Run covered %0d requests and %0d result transfers in %0d cycles.",
             table_mirror.requests, table_mirror.results_seen, cycle_count);
    $display("Statuses: ok %0d, full %0d, empty %0d, none ready %0d, bad index %0d.",
             table_mirror.status_count[ST_OK], table_mirror.status_count[ST_FULL],
             table_mirror.status_count[ST_EMPTY], table_mirror.status_count[ST_NONE],
             table_mirror.status_count[ST_BADIDX]);
    if (table_mirror.errors == 0) begin
      $display("** periodic_task_table_scheduler_core: PASSED **");
    end else begin
      $display("** periodic_task_table_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== periodic_task_table_scheduler_core.f =====
hdl/ptts_pkg.sv
hdl/ptts_div10.sv
hdl/periodic_task_table_scheduler_core.sv
dv/periodic_task_table_scheduler_core_tb.sv
